// ===== rtl/core/wma_pkg.sv =====
package wma_pkg;

  // Configuration port geometry and register map.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned WIN_SIZE_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 1'd1;

  localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RST = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } wma_state_e;

endpackage

// ===== rtl/core/wma_window_mem.sv =====
module wma_window_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 72
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // A slot that was never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/wma_divider.sv =====
module wma_divider #(
  parameter int unsigned ACC_W = 33,
  parameter int unsigned DIV_W = 8,
  parameter int unsigned Q_W   = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    busy_o,
  output logic [Q_W-1:0]          quotient_o
);

  localparam int unsigned CW = $clog2(ACC_W + 1);

  logic [CW-1:0]    cnt_q;
  logic [ACC_W-1:0] quo_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] dsr_q;
  logic             neg_q;

  logic [DIV_W:0]   trial;
  logic             fits;
  logic [ACC_W-1:0] quo_signed;

  assign trial = {rem_q, quo_q[ACC_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(ACC_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Restoring division on the magnitude, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[ACC_W-1];
      quo_q <= dividend_i[ACC_W-1] ? ACC_W'(-dividend_i) : ACC_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DIV_W'(trial - {1'b0, dsr_q}) : DIV_W'(trial);
      quo_q <= {quo_q[ACC_W-2:0], fits};
    end
  end

  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = quo_signed[Q_W-1:0];
  assign busy_o     = cnt_q != '0;

endmodule

// ===== rtl/core/weighted_moving_average_top.sv =====
// Moving-average filter over CHANNELS signed Q12.12 channels. Each request on the
// slave stream carries one sample per channel; it is stored in a circular history of
// the last MAX_WINDOW samples and one averaged sample per channel leaves on the master
// stream. Register 0 sets the window N (0 acts as 1, values above MAX_WINDOW saturate),
// register 1 selects the plain mean or the linearly weighted mean in which the newest
// sample has weight N; division truncates toward zero and the history starts at zero.
// One request is processed at a time, in steps: the request is taken, the N history
// samples are read one after another through the single read port of the sample
// memory, the multiply-accumulate pipeline drains, the bit-serial dividers run, and
// the output register is loaded. A finished result waits in that register, so the next
// request is taken while it is still unclaimed; the result after it waits for as long
// as the earlier one stays unclaimed.
module weighted_moving_average_top
  import wma_pkg::*;
#(
  parameter int unsigned CHANNELS    = 3,
  parameter int unsigned MAX_WINDOW  = 16,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // sample_x, sample_y, sample_z from bit 0 up, SAMPLE_BITS each, zero padding on top
  input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // filtered_x, filtered_y, filtered_z from bit 0 up, SAMPLE_BITS each, zero padding
  output logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned TDATA_W = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned ROW_W   = CHANNELS * SAMPLE_BITS;
  localparam int unsigned AW      = $clog2(MAX_WINDOW);
  localparam int unsigned NW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DIV_W   = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
  localparam int unsigned ACC_W   = SAMPLE_BITS + DIV_W + 1;
  localparam int unsigned PROD_W  = SAMPLE_BITS + NW + 1;

  wma_state_e state_q, state_d;

  logic [WIN_SIZE_W-1:0] win_size_q;
  logic                  wmode_q;

  logic [AW-1:0]    wp_q;
  logic [AW-1:0]    rd_q;
  logic [NW-1:0]    cnt_q;
  logic [NW-1:0]    w_q;
  logic [NW-1:0]    w1_q;
  logic             rd_v_q;
  logic             prod_v_q;
  logic [DIV_W-1:0] dsr_q;

  logic signed [PROD_W-1:0] prod_q [CHANNELS];
  logic signed [ACC_W-1:0]  acc_q  [CHANNELS];

  logic                 out_valid_q;
  logic [TDATA_W-1:0]   out_data_q;

  logic                 accept;
  logic                 rd_en;
  logic                 div_start;
  logic                 load_out;
  logic [NW-1:0]        n_eff;
  logic [2*NW-1:0]      n_sq;
  logic [ROW_W-1:0]     rd_data;
  logic [CHANNELS-1:0]  div_busy;
  logic [ROW_W-1:0]     quo_row;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Effective window: zero acts as one, large values saturate at MAX_WINDOW.
  always_comb begin
    if (win_size_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(win_size_q) > 32'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(win_size_q);
    end
  end

  assign n_sq = (2*NW)'(n_eff) * ((2*NW)'(n_eff) + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WIN_SIZE_RST;
      wmode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_SIZE:   win_size_q <= cfg_data_i[WIN_SIZE_W-1:0];
        REG_WEIGHTED_MODE: wmode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_READ;
      ST_READ:  if (cnt_q == NW'(1)) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_v_q && !prod_v_q) state_d = ST_DIV;
      ST_DIV:   if (div_busy == '0) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_DRAIN: div_start = !rd_v_q && !prod_v_q;
      ST_DIV:   ;
      ST_DONE:  load_out = !out_valid_q || m_axis_tready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rd_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= rd_en;
      prod_v_q <= rd_v_q;
      if (accept) begin
        wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Read sequencer: walks from the newest slot back through the history.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= wp_q;
      cnt_q <= n_eff;
      w_q   <= wmode_q ? n_eff : NW'(1);
      dsr_q <= wmode_q ? DIV_W'(n_sq >> 1) : DIV_W'(n_eff);
    end else if (rd_en) begin
      rd_q  <= (rd_q == '0) ? AW'(MAX_WINDOW - 1) : rd_q - 1'b1;
      cnt_q <= cnt_q - 1'b1;
      if (wmode_q) begin
        w_q <= w_q - 1'b1;
      end
    end
    if (rd_en) begin
      w1_q <= w_q;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_mac
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [NW:0]            w_s;

    assign smp = rd_data[c*SAMPLE_BITS +: SAMPLE_BITS];
    assign w_s = {1'b0, w1_q};

    always_ff @(posedge clk_i) begin
      if (rd_v_q) begin
        prod_q[c] <= w_s * smp;
      end
      if (accept) begin
        acc_q[c] <= '0;
      end else if (prod_v_q) begin
        acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
      end
    end

    wma_divider #(
      .ACC_W (ACC_W),
      .DIV_W (DIV_W),
      .Q_W   (SAMPLE_BITS)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (acc_q[c]),
      .divisor_i  (dsr_q),
      .busy_o     (div_busy[c]),
      .quotient_o (quo_row[c*SAMPLE_BITS +: SAMPLE_BITS])
    );
  end

  wma_window_mem #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (ROW_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_addr_i (wp_q),
    .wr_data_i (s_axis_tdata_i[ROW_W-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= TDATA_W'(quo_row);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
